FILE: rtl/core/lbc_pkg.sv
package lbc_pkg;

    // Default canvas store size.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // Fixed point one in Q3.12.
    localparam int Q_ONE = 4096;

    // Stream and configuration widths.
    localparam int TDATA_IN_W  = 104;
    localparam int TUSER_IN_W  = 5;
    localparam int TDATA_OUT_W = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    // Coordinate compare width, wide enough for a limit of 4096.
    localparam int COORD_W = 14;

    // Width used for address arithmetic before it is cut to the store size.
    localparam int ADDR_FULL_W = 26;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        MODE_BLEND      = 2'd0,
        MODE_READ       = 2'd1,
        MODE_READ_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        BL_ADD        = 3'd0,
        BL_DIFF       = 3'd1,
        BL_DIFF_CLAMP = 3'd2,
        BL_MAX        = 3'd3,
        BL_INVERT     = 3'd4,
        BL_ADD_CLAMP  = 3'd5
    } blend_t;

    typedef enum logic [1:0] {
        OP_BLEND      = 2'd0,
        OP_READ       = 2'd1,
        OP_READ_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_EXEC  = 2'd2
    } back_state_t;

    // One RGBA pixel, red in the lowest bits.
    typedef struct packed {
        logic signed [15:0] alpha;
        logic signed [15:0] blue;
        logic signed [15:0] green;
        logic signed [15:0] red;
    } pixel_t;

    // Command control word handed from the front to the back.
    typedef struct packed {
        op_t    op;
        blend_t kind;
        logic   in_canvas;
    } cmd_ctrl_t;

    // Saturate to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -18'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Clamp to the range zero to one.
    function automatic logic signed [15:0] clamp01(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v < 18'sd0)
        begin
            r = '0;
        end
        else if (v > 18'(Q_ONE))
        begin
            r = 16'(Q_ONE);
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Blend one channel of the stored pixel with the source.
    function automatic logic signed [15:0] blend_channel(
        input blend_t             kind,
        input logic signed [15:0] a,
        input logic signed [15:0] b,
        input logic               is_alpha
    );
        logic signed [17:0] a_x;
        logic signed [17:0] b_x;
        logic signed [17:0] sum;
        logic signed [17:0] dif;
        logic signed [17:0] adif;
        logic signed [17:0] inv;
        logic signed [15:0] r;
        a_x  = 18'(a);
        b_x  = 18'(b);
        sum  = a_x + b_x;
        dif  = a_x - b_x;
        adif = (dif < 18'sd0) ? -dif : dif;
        inv  = 18'(Q_ONE) - a_x;
        unique case (kind)
            BL_ADD:        r = sat16(sum);
            BL_DIFF:       r = sat16(adif);
            BL_DIFF_CLAMP: r = clamp01(adif);
            BL_MAX:        r = (a > b) ? a : b;
            BL_INVERT:     r = is_alpha ? a : sat16(inv);
            BL_ADD_CLAMP:  r = clamp01(sum);
            default:       r = a;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/lbc_queue.sv
module lbc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lbc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_q [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_q[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_q[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/lbc_front.sv
module lbc_front #(
    parameter int MAX_WIDTH  = lbc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lbc_pkg::MAX_HEIGHT_DEF,
    parameter int AW         = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lbc_pkg::TDATA_IN_W-1:0]   s_tdata,
    input  logic [lbc_pkg::TUSER_IN_W-1:0]   s_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             clear_done,
    input  logic                             q_full,
    output logic                             q_push,
    output lbc_pkg::cmd_ctrl_t               q_ctrl,
    output logic [AW-1:0]                    q_addr,
    output lbc_pkg::pixel_t                  q_pixel
);

    localparam int CWD = lbc_pkg::COORD_W;
    localparam int AFW = lbc_pkg::ADDR_FULL_W;

    logic [lbc_pkg::CFG_DATA_W-1:0] width_reg;
    logic [lbc_pkg::CFG_DATA_W-1:0] height_reg;

    lbc_pkg::mode_t       mode;
    lbc_pkg::blend_t      kind;
    logic signed [9:0]    pos_x;
    logic signed [9:0]    pos_y;
    logic [7:0]           off_x;
    logic [7:0]           off_y;
    logic signed [CWD-1:0] pt_x;
    logic signed [CWD-1:0] pt_y;
    logic [CWD-1:0]       wlim;
    logic [CWD-1:0]       hlim;
    logic                 pt_in_canvas;
    logic                 keep;
    logic [AFW-1:0]       addr_full;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lbc_pkg::CFG_DATA_W'(256);
            height_reg <= lbc_pkg::CFG_DATA_W'(256);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lbc_pkg::REG_CANVAS_WIDTH:  width_reg  <= cfg_data;
                lbc_pkg::REG_CANVAS_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the incoming word.
    assign mode    = lbc_pkg::mode_t'(s_tuser[1:0]);
    assign kind    = lbc_pkg::blend_t'(s_tuser[4:2]);
    assign pos_x   = s_tdata[9:0];
    assign pos_y   = s_tdata[19:10];
    assign off_x   = s_tdata[27:20];
    assign off_y   = s_tdata[35:28];
    assign q_pixel = s_tdata[99:36];

    // Canvas point and the limits in use.
    assign pt_x = CWD'(pos_x) + $signed({{(CWD - 8){1'b0}}, off_x});
    assign pt_y = CWD'(pos_y) + $signed({{(CWD - 8){1'b0}}, off_y});
    assign wlim = (CWD'(width_reg) > CWD'(MAX_WIDTH))  ? CWD'(MAX_WIDTH)  : CWD'(width_reg);
    assign hlim = (CWD'(height_reg) > CWD'(MAX_HEIGHT)) ? CWD'(MAX_HEIGHT) : CWD'(height_reg);
    assign pt_in_canvas = !pt_x[CWD-1] && !pt_y[CWD-1]
                       && (CWD'(pt_x) < wlim) && (CWD'(pt_y) < hlim);

    // Row-major store address.
    assign addr_full = AFW'(pt_y[CWD-2:0]) * AFW'(MAX_WIDTH) + AFW'(pt_x[CWD-2:0]);
    assign q_addr    = addr_full[AW-1:0];

    // Classify: words that cannot change the store or give a result are dropped here.
    always_comb
    begin
        keep             = 1'b0;
        q_ctrl.op        = lbc_pkg::OP_BLEND;
        q_ctrl.kind      = kind;
        q_ctrl.in_canvas = pt_in_canvas;
        unique case (mode)
            lbc_pkg::MODE_BLEND:
            begin
                q_ctrl.op = lbc_pkg::OP_BLEND;
                case (kind) inside
                    lbc_pkg::BL_ADD, lbc_pkg::BL_DIFF, lbc_pkg::BL_DIFF_CLAMP,
                    lbc_pkg::BL_MAX, lbc_pkg::BL_ADD_CLAMP:
                        keep = pt_in_canvas;
                    lbc_pkg::BL_INVERT:
                        keep = pt_in_canvas && (s_tdata[99:84] != '0);
                    default:
                        keep = 1'b0;
                endcase
            end
            lbc_pkg::MODE_READ:
            begin
                q_ctrl.op = lbc_pkg::OP_READ;
                keep      = 1'b1;
            end
            lbc_pkg::MODE_READ_CLEAR:
            begin
                q_ctrl.op = lbc_pkg::OP_READ_CLEAR;
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = clear_done && !q_full;
    assign q_push   = s_tvalid && s_tready && keep;

endmodule

FILE: rtl/core/lbc_back.sv
module lbc_back #(
    parameter int MAX_WIDTH  = lbc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lbc_pkg::MAX_HEIGHT_DEF,
    parameter int AW         = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    output logic                             q_pop,
    input  lbc_pkg::cmd_ctrl_t               q_ctrl,
    input  logic [AW-1:0]                    q_addr,
    input  lbc_pkg::pixel_t                  q_pixel,
    output logic                             clear_done,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lbc_pkg::TDATA_OUT_W-1:0]  m_tdata,
    output logic                             m_tuser
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    lbc_pkg::pixel_t      canvas_mem [DEPTH];
    lbc_pkg::pixel_t      rdata_reg;
    lbc_pkg::back_state_t state_reg;
    lbc_pkg::back_state_t state_next;
    logic [AW-1:0]        clr_cnt_reg;
    logic [AW-1:0]        clr_cnt_next;
    lbc_pkg::cmd_ctrl_t   cmd_ctrl_reg;
    logic [AW-1:0]        cmd_addr_reg;
    lbc_pkg::pixel_t      cmd_pixel_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    lbc_pkg::pixel_t      mem_wd;
    lbc_pkg::pixel_t      blended;
    logic                 out_free;
    logic                 out_load;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    lbc_pkg::pixel_t      m_data_reg;
    logic                 m_user_reg;

    // Blend of the stored pixel with the source, one channel each.
    assign blended.red   = lbc_pkg::blend_channel(cmd_ctrl_reg.kind, rdata_reg.red,
                                                  cmd_pixel_reg.red, 1'b0);
    assign blended.green = lbc_pkg::blend_channel(cmd_ctrl_reg.kind, rdata_reg.green,
                                                  cmd_pixel_reg.green, 1'b0);
    assign blended.blue  = lbc_pkg::blend_channel(cmd_ctrl_reg.kind, rdata_reg.blue,
                                                  cmd_pixel_reg.blue, 1'b0);
    assign blended.alpha = lbc_pkg::blend_channel(cmd_ctrl_reg.kind, rdata_reg.alpha,
                                                  cmd_pixel_reg.alpha, 1'b1);

    assign out_free   = !m_valid_reg || m_tready;
    assign clear_done = (state_reg != lbc_pkg::BK_CLEAR);

    // Sequencer: clearing pass, then read and write back one command at a time.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = cmd_addr_reg;
        mem_wd       = '0;
        out_load     = 1'b0;
        unique case (state_reg)
            lbc_pkg::BK_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_cnt_reg;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = lbc_pkg::BK_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            lbc_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = lbc_pkg::BK_EXEC;
                end
            end
            lbc_pkg::BK_EXEC:
            begin
                unique case (cmd_ctrl_reg.op) inside
                    lbc_pkg::OP_BLEND:
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = blended;
                        state_next = lbc_pkg::BK_IDLE;
                    end
                    lbc_pkg::OP_READ, lbc_pkg::OP_READ_CLEAR:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            mem_we     = cmd_ctrl_reg.in_canvas
                                      && (cmd_ctrl_reg.op == lbc_pkg::OP_READ_CLEAR);
                            state_next = lbc_pkg::BK_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = lbc_pkg::BK_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = lbc_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lbc_pkg::BK_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Command held while it is carried out.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_ctrl_reg  <= q_ctrl;
            cmd_addr_reg  <= q_addr;
            cmd_pixel_reg <= q_pixel;
        end
    end

    // Canvas store: single port, registered read.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rdata_reg <= canvas_mem[q_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            canvas_mem[mem_wa] <= mem_wd;
        end
    end

    // Output register.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= cmd_ctrl_reg.in_canvas ? rdata_reg : '0;
            m_user_reg <= cmd_ctrl_reg.in_canvas;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: rtl/core/layer_blend_compositor_core.sv
// Result path: a read word is queued, popped by the back in BK_IDLE and carried out in
// BK_EXEC, which registers its result onto m_tvalid. Commands are read and written back
// one at a time on the single canvas port; the queue lets the input run ahead.
// Reset: asynchronous, active low. After reset the canvas is cleared by a pass over
// all MAX_WIDTH * MAX_HEIGHT locations (65536 by default) with s_tready low; configuration
// writes are taken throughout.
module layer_blend_compositor_core #(
    parameter int MAX_WIDTH  = lbc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lbc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input word.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x[9:0], pos_y[19:10], off_x[27:20], off_y[35:28], src_red[51:36],
    // src_green[67:52], src_blue[83:68], src_alpha[99:84], zero pad [103:100]
    input  logic [lbc_pkg::TDATA_IN_W-1:0]   s_tdata,
    // mode[1:0], blend[4:2]
    input  logic [lbc_pkg::TUSER_IN_W-1:0]   s_tuser,
    // Result word.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_red[15:0], out_green[31:16], out_blue[47:32], out_alpha[63:48]
    output logic [lbc_pkg::TDATA_OUT_W-1:0]  m_tdata,
    // in_canvas[0]
    output logic                             m_tuser,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW    = $bits(lbc_pkg::cmd_ctrl_t) + AW + $bits(lbc_pkg::pixel_t);

    logic               clear_done;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    lbc_pkg::cmd_ctrl_t f_ctrl;
    logic [AW-1:0]      f_addr;
    lbc_pkg::pixel_t    f_pixel;
    lbc_pkg::cmd_ctrl_t b_ctrl;
    logic [AW-1:0]      b_addr;
    lbc_pkg::pixel_t    b_pixel;
    logic [QW-1:0]      q_in;
    logic [QW-1:0]      q_out;

    // Front: configuration, point and classification.
    lbc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .clear_done (clear_done),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_ctrl     (f_ctrl),
        .q_addr     (f_addr),
        .q_pixel    (f_pixel)
    );

    // Command queue between front and back.
    assign q_in = {f_ctrl, f_addr, f_pixel};
    assign {b_ctrl, b_addr, b_pixel} = q_out;

    lbc_queue #(
        .WIDTH (QW),
        .DEPTH (lbc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // Back: canvas store and result register.
    lbc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_ctrl     (b_ctrl),
        .q_addr     (b_addr),
        .q_pixel    (b_pixel),
        .clear_done (clear_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

FILE: rtl/core/lbc_checker.sv
module lbc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [lbc_pkg::TDATA_IN_W-1:0]   s_tdata,
    input logic [lbc_pkg::TUSER_IN_W-1:0]   s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [lbc_pkg::TDATA_OUT_W-1:0]  m_tdata,
    input logic                             m_tuser,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [lbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [lbc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // A result word that is not taken holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A point outside the canvas reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("outside point returned nonzero pixel");

    // Straight after reset the canvas is being cleared: no input, no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !s_tready && !m_tvalid)
        else $error("block active during clearing pass");

    // Configuration writes are never held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind layer_blend_compositor_core lbc_checker u_lbc_checker (.*);

FILE: verif/testbench.sv
module testbench;

    import lbc_pkg::*;

    localparam int CANVAS_W      = MAX_WIDTH_DEF;
    localparam int CANVAS_H      = MAX_HEIGHT_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int SHAPES        = 9;

    // Codes that the package leaves unnamed but the fields still allow.
    localparam logic [1:0]           MODE_RESERVED = 2'd3;
    localparam logic [2:0]           KIND_SPARE_A  = 3'd6;
    localparam logic [2:0]           KIND_SPARE_B  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B   = 2'd3;

    // One input word in field form.
    typedef struct packed {
        logic [1:0]        mode;
        logic [2:0]        kind;
        logic signed [9:0] pos_x;
        logic signed [9:0] pos_y;
        logic [7:0]        off_x;
        logic [7:0]        off_y;
        pixel_t            src;
    } blend_word_t;

    // One expected read result.
    typedef struct {
        pixel_t pix;
        logic   in_canvas;
    } canvas_read_t;

    // Shadow copy of the canvas and its size registers, with the reads still owed.
    class canvas_mirror;
        pixel_t       canvas [CANVAS_W * CANVAS_H];
        int unsigned  width_reg;
        int unsigned  height_reg;
        canvas_read_t reads_due [$];
        int           errors;

        function new();
            foreach (canvas[i])
                canvas[i] = '0;
            width_reg  = 256;
            height_reg = 256;
            errors     = 0;
        endfunction

        function int pending();
            return reads_due.size();
        endfunction

        function int limit_w();
            return (width_reg > CANVAS_W) ? CANVAS_W : int'(width_reg);
        endfunction

        function int limit_h();
            return (height_reg > CANVAS_H) ? CANVAS_H : int'(height_reg);
        endfunction

        function int sat_q(int v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        function int clamp_unit(int v);
            if (v < 0)
                return 0;
            if (v > Q_ONE)
                return Q_ONE;
            return v;
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_CANVAS_WIDTH:  width_reg  = value;
                REG_CANVAS_HEIGHT: height_reg = value;
                default: ;
            endcase
        endfunction

        // Apply one accepted input word and queue the result it owes, if any.
        function void note_word(blend_word_t w);
            int           x;
            int           y;
            int           addr;
            int           a;
            int           b;
            int           r;
            bit           on_canvas;
            canvas_read_t rd;
            x         = $signed(w.pos_x) + int'(w.off_x);
            y         = $signed(w.pos_y) + int'(w.off_y);
            on_canvas = x >= 0 && x < limit_w() && y >= 0 && y < limit_h();
            addr      = y * CANVAS_W + x;
            if (w.mode == MODE_BLEND)
            begin
                if (!on_canvas)
                    return;
                // Invert touches the colour channels only, and only for a visible source.
                if (w.kind == BL_INVERT)
                begin
                    if (w.src.alpha != 0)
                        for (int c = 0; c < 3; c++)
                            canvas[addr][16*c +: 16] =
                                16'(sat_q(Q_ONE - $signed(canvas[addr][16*c +: 16])));
                    return;
                end
                for (int c = 0; c < 4; c++)
                begin
                    a = $signed(canvas[addr][16*c +: 16]);
                    b = $signed(w.src[16*c +: 16]);
                    case (w.kind)
                        BL_ADD:        r = sat_q(a + b);
                        BL_DIFF:       r = sat_q(magnitude(a - b));
                        BL_DIFF_CLAMP: r = clamp_unit(magnitude(a - b));
                        BL_MAX:        r = (a > b) ? a : b;
                        BL_ADD_CLAMP:  r = clamp_unit(a + b);
                        default:       r = a;
                    endcase
                    canvas[addr][16*c +: 16] = 16'(r);
                end
            end
            else if (w.mode == MODE_READ || w.mode == MODE_READ_CLEAR)
            begin
                rd.pix       = '0;
                rd.in_canvas = on_canvas;
                if (on_canvas)
                begin
                    rd.pix = canvas[addr];
                    if (w.mode == MODE_READ_CLEAR)
                        canvas[addr] = '0;
                end
                reads_due.push_back(rd);
            end
        endfunction

        // Compare one result word against the oldest outstanding read.
        function void check_read(pixel_t got, logic got_in);
            canvas_read_t due;
            string        names [4];
            names = '{"out_red", "out_green", "out_blue", "out_alpha"};
            if (reads_due.size() == 0)
            begin
                $error("Result word arrived with no read outstanding");
                errors++;
                return;
            end
            due = reads_due.pop_front();
            for (int c = 0; c < 4; c++)
                if (got[16*c +: 16] !== due.pix[16*c +: 16])
                begin
                    $error("%s expected %0d, got %0d", names[c],
                           $signed(due.pix[16*c +: 16]), $signed(got[16*c +: 16]));
                    errors++;
                end
            if (got_in !== due.in_canvas)
            begin
                $error("in_canvas expected %0d, got %0d", due.in_canvas, got_in);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic [TUSER_IN_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    canvas_mirror sb = new();
    bit           tx_quiet = 1'b0;
    bit           rx_quiet = 1'b0;

    // Canvas shapes visited by the random part, with the number of words for each.
    int shape_w [SHAPES] = '{4, 1, 0, 3, 511, 16, 256, 2, 300};
    int shape_h [SHAPES] = '{4, 1, 5, 0, 300, 8, 1, 256, 511};
    int shape_n [SHAPES] = '{80, 50, 25, 25, 90, 80, 60, 60, 100};

    layer_blend_compositor_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one; none at all while quiet.
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Channel values biased towards the saturation and clamp limits.
    function automatic logic signed [15:0] rand_channel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 16'($urandom);
        if (r < 45)
            return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        if (r < 55)
            return $urandom_range(0, 1) ? 16'(Q_ONE) : 16'sd0;
        return 16'($urandom_range(0, 2 * Q_ONE + 2048) - Q_ONE);
    endfunction

    // Mostly words aimed inside the current canvas, some just off its edges, some wild.
    function automatic blend_word_t random_word();
        blend_word_t w;
        int          lw;
        int          lh;
        int          tx;
        int          ty;
        int          pick;
        lw   = sb.limit_w();
        lh   = sb.limit_h();
        pick = $urandom_range(0, 99);
        if (pick < 58)
            w.mode = MODE_BLEND;
        else if (pick < 76)
            w.mode = MODE_READ;
        else if (pick < 94)
            w.mode = MODE_READ_CLEAR;
        else
            w.mode = MODE_RESERVED;
        if ($urandom_range(0, 99) < 10)
            w.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
        else
            w.kind = 3'($urandom_range(BL_ADD, BL_ADD_CLAMP));
        w.src.red   = rand_channel();
        w.src.green = rand_channel();
        w.src.blue  = rand_channel();
        w.src.alpha = rand_channel();
        w.off_x     = 8'($urandom);
        w.off_y     = 8'($urandom);
        pick        = $urandom_range(0, 99);
        if (pick < 80 && lw > 0 && lh > 0)
        begin
            tx = $urandom_range(0, lw - 1);
            ty = $urandom_range(0, lh - 1);
        end
        else if (pick < 90)
        begin
            tx = (lw > 0) ? int'($urandom_range(0, lw - 1)) : 0;
            ty = (lh > 0) ? int'($urandom_range(0, lh - 1)) : 0;
            if ($urandom_range(0, 1))
                tx = $urandom_range(0, 1) ? -1 : lw;
            else
                ty = $urandom_range(0, 1) ? -1 : lh;
        end
        else
        begin
            w.pos_x = 10'($urandom);
            w.pos_y = 10'($urandom);
            return w;
        end
        w.pos_x = 10'(tx - int'(w.off_x));
        w.pos_y = 10'(ty - int'(w.off_y));
        return w;
    endfunction

    // Offer one word after a random gap and hold it until the block takes it.
    task automatic send_word(input blend_word_t w);
        int gap;
        gap = pick_gap(tx_quiet);
        if ($urandom_range(0, 29) == 0)
            tx_quiet = !tx_quiet;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, w.src, w.off_y, w.off_x, w.pos_y, w.pos_x};
        s_tuser  <= {w.kind, w.mode};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_word(w);
    endtask

    task automatic send_pixel_op(
        input logic [1:0] mode,
        input logic [2:0] kind,
        input int         px,
        input int         py,
        input int         ox,
        input int         oy,
        input int         r,
        input int         g,
        input int         b,
        input int         a
    );
        blend_word_t w;
        w.mode      = mode;
        w.kind      = kind;
        w.pos_x     = 10'(px);
        w.pos_y     = 10'(py);
        w.off_x     = 8'(ox);
        w.off_y     = 8'(oy);
        w.src.red   = 16'(r);
        w.src.green = 16'(g);
        w.src.blue  = 16'(b);
        w.src.alpha = 16'(a);
        send_word(w);
    endtask

    // Stop offering words and wait until every owed result has been seen.
    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        drain_results(SETTLE_CYCLES);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_register(idx, value);
    endtask

    // Result side: take words with random stalls and check each one taken.
    initial
    begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_read(m_tdata, m_tuser);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = pick_gap(rx_quiet);
                if ($urandom_range(0, 39) == 0)
                    rx_quiet = !rx_quiet;
            end
        end
    end

    // Stimulus.
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Saturating add and difference on the first pixel, then read and clear it.
        send_pixel_op(MODE_BLEND, BL_ADD, 0, 0, 0, 0, 32767, -32768, 4096, 1);
        send_pixel_op(MODE_BLEND, BL_ADD, 0, 0, 0, 0, 32767, -32768, 4096, 1);
        send_pixel_op(MODE_READ, BL_ADD, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pixel_op(MODE_BLEND, BL_DIFF, 0, 0, 0, 0, -32768, 32767, 0, -1);
        send_pixel_op(MODE_READ_CLEAR, BL_ADD, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pixel_op(MODE_READ, BL_ADD, 0, 0, 0, 0, 0, 0, 0, 0);

        // Every blend kind but BL_DIFF on the far corner, reached through the largest offsets.
        send_pixel_op(MODE_BLEND, BL_ADD, 0, 0, 255, 255, 100, 200, 300, 400);
        send_pixel_op(MODE_BLEND, BL_DIFF_CLAMP, 0, 0, 255, 255, 5000, -5000, 300, 0);
        send_pixel_op(MODE_BLEND, BL_MAX, 0, 0, 255, 255, -1, 5000, -32768, 32767);
        send_pixel_op(MODE_BLEND, BL_INVERT, 0, 0, 255, 255, 7, 7, 7, 0);
        send_pixel_op(MODE_BLEND, BL_INVERT, 0, 0, 255, 255, 7, 7, 7, -32768);
        send_pixel_op(MODE_BLEND, BL_ADD_CLAMP, 0, 0, 255, 255, -8192, 1, 4096, -1);
        send_pixel_op(MODE_BLEND, KIND_SPARE_A, 0, 0, 255, 255, 999, 999, 999, 999);
        send_pixel_op(MODE_BLEND, KIND_SPARE_B, 0, 0, 255, 255, 999, 999, 999, 999);
        send_pixel_op(MODE_READ, BL_ADD, 0, 0, 255, 255, 0, 0, 0, 0);
        send_pixel_op(MODE_RESERVED, BL_ADD, 0, 0, 255, 255, 0, 0, 0, 0);
        send_pixel_op(MODE_READ_CLEAR, BL_ADD, -255, 100, 255, 155, 0, 0, 0, 0);

        // Points just or far outside the canvas on every side.
        send_pixel_op(MODE_BLEND, BL_ADD, 511, 0, 0, 0, 32767, 32767, 32767, 32767);
        send_pixel_op(MODE_BLEND, BL_ADD, 1, 0, 255, 0, 32767, 32767, 32767, 32767);
        send_pixel_op(MODE_READ, BL_ADD, -512, -512, 0, 0, 0, 0, 0, 0);
        send_pixel_op(MODE_READ_CLEAR, BL_ADD, 0, 256, 0, 0, 0, 0, 0, 0);

        // Invert on both ends of the range; only the lowest value saturates.
        send_pixel_op(MODE_BLEND, BL_ADD, 1, 1, 0, 0, -32768, 32767, 0, 0);
        send_pixel_op(MODE_BLEND, BL_INVERT, 1, 1, 0, 0, 0, 0, 0, 1);
        send_pixel_op(MODE_READ_CLEAR, BL_ADD, 1, 1, 0, 0, 0, 0, 0, 0);

        // Random words across a range of canvas shapes, the extremes among them.
        for (int s = 0; s < SHAPES; s++)
        begin
            if (s == 4)
            begin
                write_register(REG_SPARE_A, 9'($urandom));
                write_register(REG_SPARE_B, 9'($urandom));
            end
            write_register(REG_CANVAS_WIDTH, 9'(shape_w[s]));
            write_register(REG_CANVAS_HEIGHT, 9'(shape_h[s]));
            for (int i = 0; i < shape_n[s]; i++)
            begin
                if (i == shape_n[s] / 2)
                    drain_results(1);
                send_word(random_word());
            end
        end

        drain_results(SETTLE_CYCLES);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: covers the canvas clearing pass and the slowest legal run several times.
    initial
    begin
        #8000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
